>>> rtl/link_reconnect_supervisor_assert.svh
// Assertion macros for the checker of the link supervisor.
`ifndef LINK_RECONNECT_SUPERVISOR_ASSERT_SVH
`define LINK_RECONNECT_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define LRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define LRS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lrs_pkg.sv
package lrs_pkg;

  // Field widths of the request and the result.
  localparam int NOW_W = 48;
  localparam int TIME_BITS_DEF = 48;

  // Request kinds.
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_OPEN   = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_RESUME = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;
  localparam logic [2:0] REQ_STOP   = 3'd5;

  // Result actions.
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_KICK       = 3'd1;
  localparam logic [2:0] ACT_CLOSE_WAIT = 3'd2;
  localparam logic [2:0] ACT_SLEEP      = 3'd3;
  localparam logic [2:0] ACT_FRAME      = 3'd4;
  localparam logic [2:0] ACT_CLOSED     = 3'd5;

  // Link modes.
  localparam logic [1:0] MODE_OPENING = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_RECONN  = 2'd2;
  localparam logic [1:0] MODE_CLOSED  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OPEN_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_OPEN_KICK_GAP    = 3'd1;
  localparam logic [2:0] CFG_NO_FRAME_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_RUN_KICK_GAP     = 3'd3;
  localparam logic [2:0] CFG_FAIL_LIMIT       = 3'd4;
  localparam logic [2:0] CFG_SHORT_SLEEP_MS   = 3'd5;
  localparam logic [2:0] CFG_BACKOFF_START_MS = 3'd6;
  localparam logic [2:0] CFG_BACKOFF_CAP_MS   = 3'd7;

  // Configuration reset values.
  localparam logic [31:0] RST_OPEN_TIMEOUT     = 32'd5000000;
  localparam logic [31:0] RST_OPEN_KICK_GAP    = 32'd2000000;
  localparam logic [31:0] RST_NO_FRAME_TIMEOUT = 32'd3000000;
  localparam logic [31:0] RST_RUN_KICK_GAP     = 32'd2000000;
  localparam logic [15:0] RST_FAIL_LIMIT       = 16'd30;
  localparam logic [15:0] RST_SHORT_SLEEP_MS   = 16'd10;
  localparam logic [15:0] RST_BACKOFF_START_MS = 16'd500;
  localparam logic [15:0] RST_BACKOFF_CAP_MS   = 16'd10000;

  typedef struct packed {
    logic [2:0]       req_type;
    logic             success;
    logic [NOW_W-1:0] now_us;
  } lrs_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] wait_ms;
    logic [1:0]  link_state;
    logic [31:0] frame_count;
    logic [31:0] reconnects;
    logic [15:0] open_failures;
  } lrs_out_t;

  typedef struct packed {
    logic [31:0] open_timeout;
    logic [31:0] open_kick_gap;
    logic [31:0] no_frame_timeout;
    logic [31:0] run_kick_gap;
    logic [15:0] fail_limit;
    logic [15:0] short_sleep_ms;
    logic [15:0] backoff_start_ms;
    logic [15:0] backoff_cap_ms;
  } lrs_cfg_t;

endpackage

>>> rtl/lrs_engine.sv
module lrs_engine #(
  parameter int TIME_BITS = lrs_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  lrs_pkg::lrs_in_t  item,
  input  lrs_pkg::lrs_cfg_t cfg,
  output lrs_pkg::lrs_out_t result
);

  // Stamps keep only the time bits that survive the time mask.
  localparam int STAMP_W = (TIME_BITS < lrs_pkg::NOW_W) ? TIME_BITS : lrs_pkg::NOW_W;

  logic [1:0]         mode, mode_next;
  logic [15:0]        read_fail_run, read_fail_run_next;
  logic [15:0]        open_fail_run, open_fail_run_next;
  logic [31:0]        reconnect_total, reconnect_total_next;
  logic [15:0]        backoff_now, backoff_now_next;
  logic [STAMP_W-1:0] open_began, open_began_next;
  logic [STAMP_W-1:0] last_good, last_good_next;
  logic [STAMP_W-1:0] last_open_kick, last_open_kick_next;
  logic [STAMP_W-1:0] last_run_kick, last_run_kick_next;
  logic [31:0]        frame_num, frame_num_next;

  logic [STAMP_W-1:0] now;
  logic [2:0]         action;
  logic [15:0]        wait_ms;
  logic [15:0]        read_fail_inc;
  logic [15:0]        open_fail_inc;
  logic [31:0]        reconnect_inc;
  logic [16:0]        backoff_dbl;
  logic [15:0]        backoff_capped;
  logic               stall;
  logic               open_late;
  logic               open_gap_ok;
  logic               run_gap_ok;

  // A time is elapsed only when now is not behind the stamp.
  function automatic logic elapsed(input logic [STAMP_W-1:0] t_now,
                                   input logic [STAMP_W-1:0] t_since,
                                   input logic [31:0]        limit);
    logic [STAMP_W-1:0] diff;
    diff = t_now - t_since;
    return (t_now >= t_since) && (diff >= STAMP_W'(limit));
  endfunction

  assign now = item.now_us[STAMP_W-1:0];

  // Saturating increments and the capped doubling of the backoff.
  assign read_fail_inc  = (read_fail_run == 16'hFFFF) ? read_fail_run : read_fail_run + 16'd1;
  assign open_fail_inc  = (open_fail_run == 16'hFFFF) ? open_fail_run : open_fail_run + 16'd1;
  assign reconnect_inc  = (reconnect_total == 32'hFFFF_FFFF) ? reconnect_total
                                                             : reconnect_total + 32'd1;
  assign backoff_dbl    = {backoff_now, 1'b0};
  assign backoff_capped = (backoff_dbl > {1'b0, cfg.backoff_cap_ms}) ? cfg.backoff_cap_ms
                                                                      : backoff_dbl[15:0];

  // Timeout checks; a zero stamp means the stamp was never set.
  assign stall       = (last_good != '0) && elapsed(now, last_good, cfg.no_frame_timeout);
  assign open_late   = (open_began != '0) && elapsed(now, open_began, cfg.open_timeout);
  assign open_gap_ok = (last_open_kick == '0) || elapsed(now, last_open_kick, cfg.open_kick_gap);
  assign run_gap_ok  = (last_run_kick == '0) || elapsed(now, last_run_kick, cfg.run_kick_gap);

  // Next state and action for the request in the input register.
  always_comb begin
    mode_next            = mode;
    read_fail_run_next   = read_fail_run;
    open_fail_run_next   = open_fail_run;
    reconnect_total_next = reconnect_total;
    backoff_now_next     = backoff_now;
    open_began_next      = open_began;
    last_good_next       = last_good;
    last_open_kick_next  = last_open_kick;
    last_run_kick_next   = last_run_kick;
    frame_num_next       = frame_num;
    action               = lrs_pkg::ACT_NONE;
    wait_ms              = 16'd0;
    case (item.req_type)
      lrs_pkg::REQ_START: begin
        if (mode == lrs_pkg::MODE_CLOSED) begin
          mode_next          = lrs_pkg::MODE_OPENING;
          read_fail_run_next = 16'd0;
          last_good_next     = now;
        end
      end
      lrs_pkg::REQ_OPEN: begin
        if (mode == lrs_pkg::MODE_OPENING) begin
          if (!item.success) begin
            open_fail_run_next   = open_fail_inc;
            mode_next            = lrs_pkg::MODE_RECONN;
            reconnect_total_next = reconnect_inc;
            wait_ms              = backoff_now;
            action               = lrs_pkg::ACT_CLOSE_WAIT;
          end else begin
            open_fail_run_next  = 16'd0;
            last_open_kick_next = '0;
            open_began_next     = '0;
            last_good_next      = now;
            backoff_now_next    = cfg.backoff_start_ms;
            mode_next           = lrs_pkg::MODE_RUNNING;
          end
        end
      end
      lrs_pkg::REQ_READ: begin
        if (mode == lrs_pkg::MODE_RUNNING) begin
          if (!item.success) begin
            read_fail_run_next = read_fail_inc;
            if ((read_fail_inc >= cfg.fail_limit) || stall) begin
              mode_next            = lrs_pkg::MODE_RECONN;
              reconnect_total_next = reconnect_inc;
              wait_ms              = backoff_now;
              action               = lrs_pkg::ACT_CLOSE_WAIT;
            end else begin
              wait_ms = cfg.short_sleep_ms;
              action  = lrs_pkg::ACT_SLEEP;
            end
          end else begin
            read_fail_run_next = 16'd0;
            last_good_next     = now;
            backoff_now_next   = cfg.backoff_start_ms;
            frame_num_next     = frame_num + 32'd1;
            action             = lrs_pkg::ACT_FRAME;
          end
        end
      end
      lrs_pkg::REQ_RESUME: begin
        if (mode == lrs_pkg::MODE_RECONN) begin
          backoff_now_next = backoff_capped;
          open_began_next  = now;
          mode_next        = lrs_pkg::MODE_OPENING;
        end
      end
      lrs_pkg::REQ_TICK: begin
        if (mode == lrs_pkg::MODE_OPENING) begin
          if (open_late && open_gap_ok) begin
            last_open_kick_next = now;
            action              = lrs_pkg::ACT_KICK;
          end
        end else if (mode == lrs_pkg::MODE_RUNNING) begin
          if (stall && run_gap_ok) begin
            last_run_kick_next = now;
            action             = lrs_pkg::ACT_KICK;
          end
        end
      end
      lrs_pkg::REQ_STOP: begin
        mode_next = lrs_pkg::MODE_CLOSED;
        action    = lrs_pkg::ACT_CLOSED;
      end
      default: begin
        action = lrs_pkg::ACT_NONE;
      end
    endcase
  end

  // The result reports the state after the request.
  always_comb begin
    result.action        = action;
    result.wait_ms       = wait_ms;
    result.link_state    = mode_next;
    result.frame_count   = frame_num_next;
    result.reconnects    = reconnect_total_next;
    result.open_failures = open_fail_run_next;
  end

  // Supervisor state advances once per request handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= lrs_pkg::MODE_CLOSED;
      read_fail_run   <= 16'd0;
      open_fail_run   <= 16'd0;
      reconnect_total <= 32'd0;
      backoff_now     <= lrs_pkg::RST_BACKOFF_START_MS;
      open_began      <= '0;
      last_good       <= '0;
      last_open_kick  <= '0;
      last_run_kick   <= '0;
      frame_num       <= 32'd0;
    end else if (fire) begin
      mode            <= mode_next;
      read_fail_run   <= read_fail_run_next;
      open_fail_run   <= open_fail_run_next;
      reconnect_total <= reconnect_total_next;
      backoff_now     <= backoff_now_next;
      open_began      <= open_began_next;
      last_good       <= last_good_next;
      last_open_kick  <= last_open_kick_next;
      last_run_kick   <= last_run_kick_next;
      frame_num       <= frame_num_next;
    end
  end

endmodule

>>> rtl/link_reconnect_supervisor.sv
// Link reconnect supervisor.
// Requests (start, open result, read result, resume, watchdog tick, stop)
// arrive on in_valid/in_ready with payload in_data; each request yields exactly
// one result on out_valid/out_ready with payload out_data: the action, the
// requested wait, the link state after the request and the three counters.
// A request is first captured in an input register; the supervisor logic
// then evaluates it against the link state and the result enters the output
// register. One request per cycle is sustained while the receiver takes
// results; the only loop is the update of the link state registers.
// When the receiver stalls, the result holds in the output register and one
// more request is still taken into the input register; in_ready drops only
// when both registers are full.
// Reset (rst, synchronous) closes the link, clears counters and stamps,
// loads the backoff start value and restores all configuration registers.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
module link_reconnect_supervisor #(
  parameter int TIME_BITS = lrs_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrs_pkg::lrs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lrs_pkg::lrs_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  lrs_pkg::lrs_cfg_t cfg;
  logic              s1_valid;
  lrs_pkg::lrs_in_t  s1_item;
  logic              advance;
  lrs_pkg::lrs_out_t step_result;

  // The input register moves on when the output register is free or draining.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_timeout     <= lrs_pkg::RST_OPEN_TIMEOUT;
      cfg.open_kick_gap    <= lrs_pkg::RST_OPEN_KICK_GAP;
      cfg.no_frame_timeout <= lrs_pkg::RST_NO_FRAME_TIMEOUT;
      cfg.run_kick_gap     <= lrs_pkg::RST_RUN_KICK_GAP;
      cfg.fail_limit       <= lrs_pkg::RST_FAIL_LIMIT;
      cfg.short_sleep_ms   <= lrs_pkg::RST_SHORT_SLEEP_MS;
      cfg.backoff_start_ms <= lrs_pkg::RST_BACKOFF_START_MS;
      cfg.backoff_cap_ms   <= lrs_pkg::RST_BACKOFF_CAP_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        lrs_pkg::CFG_OPEN_TIMEOUT:     cfg.open_timeout     <= cfg_data;
        lrs_pkg::CFG_OPEN_KICK_GAP:    cfg.open_kick_gap    <= cfg_data;
        lrs_pkg::CFG_NO_FRAME_TIMEOUT: cfg.no_frame_timeout <= cfg_data;
        lrs_pkg::CFG_RUN_KICK_GAP:     cfg.run_kick_gap     <= cfg_data;
        lrs_pkg::CFG_FAIL_LIMIT:       cfg.fail_limit       <= cfg_data[15:0];
        lrs_pkg::CFG_SHORT_SLEEP_MS:   cfg.short_sleep_ms   <= cfg_data[15:0];
        lrs_pkg::CFG_BACKOFF_START_MS: cfg.backoff_start_ms <= cfg_data[15:0];
        lrs_pkg::CFG_BACKOFF_CAP_MS:   cfg.backoff_cap_ms   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  lrs_engine #(
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (s1_item),
    .cfg   (cfg),
    .result(step_result)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

>>> rtl/lrs_checker.sv
`include "link_reconnect_supervisor_assert.svh"

module lrs_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input lrs_pkg::lrs_out_t out_data
);

  // A stalled result stays put.
  `LRS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Only a close-and-wait or a short sleep carries a wait.
  `LRS_ASSERT_SAME(a_wait_only, clk, rst, out_valid && (out_data.action != lrs_pkg::ACT_CLOSE_WAIT) && (out_data.action != lrs_pkg::ACT_SLEEP), out_data.wait_ms == 16'd0, "wait given without a waiting action")

  // A close-and-wait leaves the link reconnecting, a stop leaves it closed.
  `LRS_ASSERT_SAME(a_close_wait_mode, clk, rst, out_valid && (out_data.action == lrs_pkg::ACT_CLOSE_WAIT), out_data.link_state == lrs_pkg::MODE_RECONN, "close and wait outside reconnecting")
  `LRS_ASSERT_SAME(a_stop_mode, clk, rst, out_valid && (out_data.action == lrs_pkg::ACT_CLOSED), out_data.link_state == lrs_pkg::MODE_CLOSED, "stop did not close the link")

  // No result is shown in the cycle after reset.
  `LRS_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

endmodule

bind link_reconnect_supervisor lrs_checker u_lrs_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
